// ===== hw/rtl/lrs_pkg.sv =====
// Shared types and constants of the longest repeated substring finder.
package lrs_pkg;

  localparam int LETTER_W = 5;
  localparam int OUT_W    = 12;
  localparam int HASH_W   = 24;
  localparam logic [HASH_W-1:0] HASH_BASE = 24'd26;

  typedef struct packed {
    logic [LETTER_W-1:0] letter;
    logic                last;
    logic                keep;
  } cmd_t;

endpackage

// ===== hw/rtl/lrs_front.sv =====
// Front part: accepts letters and marks each one as kept or dropped.
module lrs_front #(
  parameter int MAX_TEXT = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lrs_pkg::LETTER_W-1:0]  letter,
  input  logic                          last_letter,
  input  logic                          q_full,
  output logic                          q_push,
  output lrs_pkg::cmd_t                 q_data
);

  localparam int CW = $clog2(MAX_TEXT + 1);

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  assign in_stall      = q_full;
  assign q_push        = in_valid && !q_full;
  assign q_data.letter = letter;
  assign q_data.last   = last_letter;
  assign q_data.keep   = (count < CW'(MAX_TEXT));

  always_comb begin
    count_next = count;
    if (q_push) begin
      if (last_letter) begin
        count_next = '0;
      end else if (q_data.keep) begin
        count_next = count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

endmodule

// ===== hw/rtl/lrs_queue.sv =====
// Two-entry queue that carries classified letters from the front to the back.
module lrs_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  lrs_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          pop_valid,
  output lrs_pkg::cmd_t pop_data
);

  lrs_pkg::cmd_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full      = (fill == 2'd2);
  assign pop_valid = (fill != 2'd0);
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop && pop_valid) begin
        rd_ptr <= !rd_ptr;
      end
      fill <= fill + 2'(push) - 2'(pop && pop_valid);
    end
  end

endmodule

// ===== hw/rtl/lrs_back.sv =====
// Back part: stores the text, runs the length search and holds the result.
module lrs_back #(
  parameter int MAX_TEXT     = 4096,
  parameter int HASH_BUCKETS = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  lrs_pkg::cmd_t               q_data,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [lrs_pkg::OUT_W-1:0]   dup_start,
  output logic [lrs_pkg::OUT_W-1:0]   dup_length,
  output logic                        overflow
);

  localparam int AW = $clog2(MAX_TEXT);
  localparam int CW = $clog2(MAX_TEXT + 1);
  localparam int PW = AW + 1;
  localparam int BW = $clog2(HASH_BUCKETS);
  localparam int NB = 1 << BW;
  localparam int HW = lrs_pkg::HASH_W;
  localparam int LW = lrs_pkg::LETTER_W;
  localparam logic [PW-1:0] NULLP = {1'b1, {AW{1'b0}}};

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_START = 10'b0000000010,
    ST_CLEAR = 10'b0000000100,
    ST_RD    = 10'b0000001000,
    ST_HASH  = 10'b0000010000,
    ST_HEAD  = 10'b0000100000,
    ST_CHK   = 10'b0001000000,
    ST_FILE  = 10'b0010000000,
    ST_CMP   = 10'b0100000000,
    ST_CMPD  = 10'b1000000000
  } state_t;

  // Memories.
  logic [LW-1:0] text_mem  [MAX_TEXT];
  logic [HW-1:0] hash_mem  [MAX_TEXT];
  logic [PW-1:0] link_mem  [MAX_TEXT];
  logic [PW-1:0] head_mem  [NB];

  state_t state, state_next;
  logic [CW-1:0] n, n_next, lo, lo_next, hi, hi_next, mid, mid_next;
  logic [CW-1:0] i, i_next, k, k_next;
  logic [HW-1:0] h, h_next, pw, pw_next;
  logic [AW-1:0] w, w_next, best_start, best_start_next;
  logic [CW-1:0] best_len, best_len_next;
  logic [PW-1:0] j, j_next, link_r, link_r_next, head_r, head_r_next;
  logic [BW-1:0] clr, clr_next, bkt, bkt_next;
  logic          ovf, ovf_next;
  logic          done;

  logic [LW-1:0] ta, tb;
  logic [HW-1:0] hq;
  logic [PW-1:0] lq, head_q;

  logic          t_we, hl_we, hd_we;
  logic [AW-1:0] t_wa, ta_addr, tb_addr, hl_addr;
  logic [BW-1:0] hd_ra, hd_wa;
  logic [PW-1:0] hd_wd;

  logic [HW-1:0] hn;
  logic [CW-1:0] i_lag, ja_sum, wa_sum, n_new;
  logic [31:0]   start_wide, len_wide;

  always_ff @(posedge clk) begin
    if (t_we) begin
      text_mem[t_wa] <= q_data.letter;
    end
    ta <= text_mem[ta_addr];
    tb <= text_mem[tb_addr];
  end

  always_ff @(posedge clk) begin
    if (hl_we) begin
      hash_mem[w] <= h;
      link_mem[w] <= head_r;
    end
    hq <= hash_mem[hl_addr];
    lq <= link_mem[hl_addr];
  end

  always_ff @(posedge clk) begin
    if (hd_we) begin
      head_mem[hd_wa] <= hd_wd;
    end
    head_q <= head_mem[hd_ra];
  end

  always_comb begin
    hn = h * lrs_pkg::HASH_BASE + HW'(ta);
    if (i >= mid) begin
      hn = hn - pw * HW'(tb);
    end
  end

  assign i_lag  = i - mid;
  assign ja_sum = CW'(j[AW-1:0]) + k;
  assign wa_sum = CW'(w) + k;
  assign n_new  = n + CW'(q_data.keep);

  always_comb begin
    state_next      = state;
    n_next          = n;
    lo_next         = lo;
    hi_next         = hi;
    mid_next        = mid;
    i_next          = i;
    k_next          = k;
    h_next          = h;
    pw_next         = pw;
    w_next          = w;
    j_next          = j;
    link_r_next     = link_r;
    head_r_next     = head_r;
    clr_next        = clr;
    bkt_next        = bkt;
    best_start_next = best_start;
    best_len_next   = best_len;
    ovf_next        = ovf;
    done            = 1'b0;
    q_pop           = 1'b0;
    t_we            = 1'b0;
    t_wa            = n[AW-1:0];
    ta_addr         = i[AW-1:0];
    tb_addr         = i_lag[AW-1:0];
    hl_we           = 1'b0;
    hl_addr         = j[AW-1:0];
    hd_we           = 1'b0;
    hd_wa           = clr;
    hd_wd           = NULLP;
    hd_ra           = hn[BW-1:0];

    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          t_we  = q_data.keep;
          n_next = n_new;
          if (!q_data.keep) begin
            ovf_next = 1'b1;
          end
          if (q_data.last) begin
            best_start_next = '0;
            best_len_next   = '0;
            lo_next         = CW'(1);
            hi_next         = n_new - CW'(1);
            state_next      = ST_START;
          end
        end
      end
      ST_START: begin
        if (lo <= hi) begin
          mid_next   = lo + ((hi - lo) >> 1);
          clr_next   = '0;
          state_next = ST_CLEAR;
        end else if (!out_valid || !out_stall) begin
          done       = 1'b1;
          n_next     = '0;
          ovf_next   = 1'b0;
          state_next = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        hd_we    = 1'b1;
        clr_next = clr + BW'(1);
        if (clr == BW'(NB - 1)) begin
          i_next     = '0;
          h_next     = '0;
          pw_next    = HW'(1);
          state_next = ST_RD;
        end
      end
      ST_RD: begin
        state_next = ST_HASH;
      end
      ST_HASH: begin
        h_next = hn;
        if (i < mid) begin
          pw_next = pw * lrs_pkg::HASH_BASE;
        end
        if (i + CW'(1) < mid) begin
          i_next     = i + CW'(1);
          state_next = ST_RD;
        end else begin
          w_next     = AW'(i + CW'(1) - mid);
          bkt_next   = hn[BW-1:0];
          state_next = ST_HEAD;
        end
      end
      ST_HEAD: begin
        head_r_next = head_q;
        j_next      = head_q;
        hl_addr     = head_q[AW-1:0];
        state_next  = head_q[AW] ? ST_FILE : ST_CHK;
      end
      ST_CHK: begin
        link_r_next = lq;
        if (hq == h) begin
          k_next     = '0;
          state_next = ST_CMP;
        end else begin
          j_next     = lq;
          hl_addr    = lq[AW-1:0];
          state_next = lq[AW] ? ST_FILE : ST_CHK;
        end
      end
      ST_CMP: begin
        ta_addr    = ja_sum[AW-1:0];
        tb_addr    = wa_sum[AW-1:0];
        state_next = ST_CMPD;
      end
      ST_CMPD: begin
        if (ta != tb) begin
          j_next     = link_r;
          hl_addr    = link_r[AW-1:0];
          state_next = link_r[AW] ? ST_FILE : ST_CHK;
        end else if (k + CW'(1) == mid) begin
          // Every letter matched: this length repeats.
          best_start_next = j[AW-1:0];
          best_len_next   = mid;
          lo_next         = mid + CW'(1);
          state_next      = ST_START;
        end else begin
          k_next     = k + CW'(1);
          state_next = ST_CMP;
        end
      end
      ST_FILE: begin
        hl_we = 1'b1;
        hd_we = 1'b1;
        hd_wa = bkt;
        hd_wd = {1'b0, w};
        if (i + CW'(1) == n) begin
          hi_next    = mid - CW'(1);
          state_next = ST_START;
        end else begin
          i_next     = i + CW'(1);
          state_next = ST_RD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      n     <= '0;
      ovf   <= 1'b0;
    end else begin
      state <= state_next;
      n     <= n_next;
      ovf   <= ovf_next;
    end
  end

  always_ff @(posedge clk) begin
    lo         <= lo_next;
    hi         <= hi_next;
    mid        <= mid_next;
    i          <= i_next;
    k          <= k_next;
    h          <= h_next;
    pw         <= pw_next;
    w          <= w_next;
    j          <= j_next;
    link_r     <= link_r_next;
    head_r     <= head_r_next;
    clr        <= clr_next;
    bkt        <= bkt_next;
    best_start <= best_start_next;
    best_len   <= best_len_next;
  end

  assign start_wide = 32'(best_start);
  assign len_wide   = 32'(best_len);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      dup_start  <= start_wide[lrs_pkg::OUT_W-1:0];
      dup_length <= len_wide[lrs_pkg::OUT_W-1:0];
      overflow   <= ovf;
    end
  end

endmodule

// ===== hw/rtl/longest_repeated_substring.sv =====
// Top level of the longest repeated substring finder.
//
//   channel | direction | handshake             | fields
//   input   | in        | in_valid / in_stall   | letter, last_letter
//   output  | out       | out_valid / out_stall | dup_start, dup_length, overflow
//
// Letters load at one per cycle while the back part is idle, through a two-entry queue
// into the text memory. After the last letter the search takes about log2(n) probes;
// each probe passes the start state and clears every hash bucket, then hashes the
// letters into each window in turn, walks the window's bucket chain, compares letters
// of entries whose hash matches and files the window unless a full match ends the probe.
// Input stalls once the queue fills during a search. Reset clears control only.
// The result waits in an output register while the next text loads.
module longest_repeated_substring #(
  parameter int MAX_TEXT     = 4096,
  parameter int HASH_BUCKETS = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [lrs_pkg::LETTER_W-1:0] letter,
  input  logic                        last_letter,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [lrs_pkg::OUT_W-1:0]   dup_start,
  output logic [lrs_pkg::OUT_W-1:0]   dup_length,
  output logic                        overflow
);

  lrs_pkg::cmd_t push_data, pop_data;
  logic push, full, pop, pop_valid;

  lrs_front #(.MAX_TEXT(MAX_TEXT)) u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .letter(letter), .last_letter(last_letter),
    .q_full(full), .q_push(push), .q_data(push_data)
  );

  lrs_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data), .full(full),
    .pop(pop), .pop_valid(pop_valid), .pop_data(pop_data)
  );

  lrs_back #(.MAX_TEXT(MAX_TEXT), .HASH_BUCKETS(HASH_BUCKETS)) u_back (
    .clk(clk), .rst(rst), .q_valid(pop_valid), .q_data(pop_data), .q_pop(pop),
    .out_valid(out_valid), .out_stall(out_stall), .dup_start(dup_start),
    .dup_length(dup_length), .overflow(overflow)
  );

endmodule

// ===== hw/rtl/lrs_checker.sv =====
// Port checker for the longest repeated substring finder, with its bind.
module lrs_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [lrs_pkg::OUT_W-1:0] dup_start,
  input logic [lrs_pkg::OUT_W-1:0] dup_length
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(dup_start) && $stable(dup_length))
    else $error("result changed while stalled");

  a_no_repeat_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && (dup_length == '0) |-> (dup_start == '0))
    else $error("start given without a repeat");

  a_reset_idle: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid)
    else $error("result shown right after reset");

endmodule

bind longest_repeated_substring lrs_checker u_chk (.*);

// ===== sim/tb.sv =====
// Self-checking testbench for the longest repeated substring finder.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_TEXT   = 4096;
  localparam int LATE_ITEMS = 300;

  typedef struct {
    logic [4:0]  lt;
    logic        lst;
    bit          typed;
    logic [11:0] st;
    logic [11:0] len;
    logic        ovf;
  } stim_row_t;

  typedef struct {
    logic [11:0] st;
    logic [11:0] len;
    logic        ovf;
  } repeat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [lrs_pkg::LETTER_W-1:0] letter = '0;
  logic last_letter = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [lrs_pkg::OUT_W-1:0] dup_start;
  logic [lrs_pkg::OUT_W-1:0] dup_length;
  logic overflow;

  repeat_t expected_repeats[$];
  logic [4:0] text_buf[$];
  bit   text_ovf = 1'b0;
  bit   idle_on = 1'b1;
  int   mismatches = 0;
  int   texts_done = 0;
  int   items_sent = 0;

  stim_row_t directed[24] = '{
    '{5'd0,  1'b1, 1'b1, 12'd0, 12'd0, 1'b0},
    '{5'd0,  1'b0, 1'b0, 12'd0, 12'd0, 1'b0},
    '{5'd0,  1'b1, 1'b1, 12'd0, 12'd1, 1'b0},
    '{5'd0,  1'b0, 1'b0, 12'd0, 12'd0, 1'b0},
    '{5'd1,  1'b1, 1'b1, 12'd0, 12'd0, 1'b0},
    '{5'd31, 1'b0, 1'b0, 12'd0, 12'd0, 1'b0},
    '{5'd31, 1'b1, 1'b1, 12'd0, 12'd1, 1'b0},
    '{5'd25, 1'b0, 1'b0, 12'd0, 12'd0, 1'b0},
    '{5'd26, 1'b0, 1'b0, 12'd0, 12'd0, 1'b0},
    '{5'd25, 1'b0, 1'b0, 12'd0, 12'd0, 1'b0},
    '{5'd26, 1'b1, 1'b1, 12'd0, 12'd2, 1'b0},
    '{5'd27, 1'b0, 1'b0, 12'd0, 12'd0, 1'b0},
    '{5'd28, 1'b0, 1'b0, 12'd0, 12'd0, 1'b0},
    '{5'd29, 1'b0, 1'b0, 12'd0, 12'd0, 1'b0},
    '{5'd30, 1'b0, 1'b0, 12'd0, 12'd0, 1'b0},
    '{5'd27, 1'b0, 1'b0, 12'd0, 12'd0, 1'b0},
    '{5'd28, 1'b0, 1'b0, 12'd0, 12'd0, 1'b0},
    '{5'd29, 1'b0, 1'b0, 12'd0, 12'd0, 1'b0},
    '{5'd30, 1'b1, 1'b1, 12'd0, 12'd4, 1'b0},
    '{5'd1,  1'b0, 1'b0, 12'd0, 12'd0, 1'b0},
    '{5'd2,  1'b0, 1'b0, 12'd0, 12'd0, 1'b0},
    '{5'd1,  1'b0, 1'b0, 12'd0, 12'd0, 1'b0},
    '{5'd2,  1'b0, 1'b0, 12'd0, 12'd0, 1'b0},
    '{5'd1,  1'b1, 1'b0, 12'd0, 12'd0, 1'b0}
  };

  longest_repeated_substring u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .letter(letter), .last_letter(last_letter),
    .out_valid(out_valid), .out_stall(out_stall),
    .dup_start(dup_start), .dup_length(dup_length), .overflow(overflow)
  );

  always #10 clk = ~clk;

  // First window in scan order that equals an earlier one; pos gets the earlier start.
  function automatic bit find_repeat(input string s, input int n, input int len,
                                     output int pos);
    int seen[string];
    string w;
    pos = 0;
    for (int i = 0; i + len <= n; i++) begin
      w = s.substr(i, i + len - 1);
      if (seen.exists(w)) begin
        pos = seen[w];
        return 1'b1;
      end
      seen[w] = i;
    end
    return 1'b0;
  endfunction

  function automatic repeat_t longest_repeat(input bit ovf);
    repeat_t r;
    string s;
    int n, lo, hi, mid, pos;
    s = "";
    n = text_buf.size();
    for (int i = 0; i < n; i++) s = {s, string'(byte'(8'd65 + text_buf[i]))};
    r.st = '0;
    r.len = '0;
    r.ovf = ovf;
    lo = 1;
    hi = n - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (find_repeat(s, n, mid, pos)) begin
        r.st = pos[11:0];
        r.len = mid[11:0];
        lo = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
    return r;
  endfunction

  task automatic send_letter(input logic [4:0] lt, input logic lst, input bit typed,
                             input repeat_t typed_res);
    repeat_t r;
    if (idle_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    letter <= lt;
    last_letter <= lst;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (text_buf.size() < MAX_TEXT) text_buf.insert(text_buf.size(), lt);
    else text_ovf = 1'b1;
    if (lst) begin
      r = longest_repeat(text_ovf);
      expected_repeats.insert(expected_repeats.size(), typed ? typed_res : r);
      text_buf.delete();
      text_ovf = 1'b0;
      texts_done++;
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_repeats.size() != 0);
  endtask

  task automatic send_random_text(input int n);
    logic [4:0] chunk[$];
    int alpha, k;
    repeat_t none;
    none = '{12'd0, 12'd0, 1'b0};
    case ($urandom_range(0, 3))
      0: alpha = 2;
      1: alpha = 4;
      2: alpha = 26;
      default: alpha = 32;
    endcase
    // Most texts splice in a copy of an earlier chunk to force a long repeat.
    k = 0;
    while (k < n) begin
      if (chunk.size() > 0 && $urandom_range(0, 3) == 0) begin
        foreach (chunk[i]) begin
          if (k < n) begin
            send_letter(chunk[i], k == n - 1, 1'b0, none);
            k++;
          end
        end
      end else begin
        chunk.insert(chunk.size(), 5'($urandom_range(0, alpha - 1)));
        send_letter(chunk[chunk.size() - 1], k == n - 1, 1'b0, none);
        k++;
      end
    end
  endtask

  initial begin
    repeat_t typed_res;
    int n, budget;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    foreach (directed[i]) begin
      typed_res = '{directed[i].st, directed[i].len, directed[i].ovf};
      send_letter(directed[i].lt, directed[i].lst, directed[i].typed, typed_res);
    end
    drain_results();
    // One text past the buffer capacity: the final letters are dropped.
    for (int i = 0; i < MAX_TEXT + 4; i++)
      send_letter(5'($urandom_range(0, 31)), i == MAX_TEXT + 3, 1'b0, typed_res);
    budget = 2000;
    while (budget > 0) begin
      if (budget < LATE_ITEMS) idle_on = 1'b0;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 48);
      send_random_text(n);
      budget -= n;
      if ($urandom_range(0, 9) == 0) drain_results();
    end
    drain_results();
    repeat (20) @(posedge clk);
    $display("Checked %0d texts from %0d letters, including an overflowing text.",
             texts_done, items_sent);
    $display("Mismatches: %0d", mismatches);
    if (mismatches == 0 && expected_repeats.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    @(negedge rst);
    forever begin
      if (idle_on && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    repeat_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_repeats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: start %0d length %0d overflow %0d",
                   dup_start, dup_length, overflow);
      end else begin
        e = expected_repeats.pop_front();
        if (dup_start !== e.st || dup_length !== e.len || overflow !== e.ovf) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected start %0d length %0d overflow %0d, got %0d %0d %0d",
                     e.st, e.len, e.ovf, dup_start, dup_length, overflow);
        end
      end
    end
  end

  initial begin
    #100ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
